### rtl/core/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants for the stereo disparity reprojection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

	// matrix register file
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 4;
	localparam int REG_W = 64;

	localparam logic [REG_W-1:0] RST_ROW0_C01 = 64'h0000_0001_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW0_C23 = 64'h0;
	localparam logic [REG_W-1:0] RST_ROW1_C01 = 64'h0000_0000_0001_0000;
	localparam logic [REG_W-1:0] RST_ROW1_C23 = 64'h0;
	localparam logic [REG_W-1:0] RST_ROW2_C01 = 64'h0;
	localparam logic [REG_W-1:0] RST_ROW2_C23 = 64'h0001_0000_0000_0000;
	localparam logic [REG_W-1:0] RST_ROW3_C01 = 64'h0;
	localparam logic [REG_W-1:0] RST_ROW3_C23 = 64'h0000_0000_0001_0000;

	// datapath widths
	localparam int COEF_W = 32;
	localparam int H_W = 18;                  // homogeneous term, signed
	localparam int PROD_W = COEF_W + H_W;     // 50
	localparam int DOT_W = PROD_W + 3;        // 53, signed dot product
	localparam int MAG_W = DOT_W - 1;         // 52, magnitude
	localparam int QUO_W = 34;                // quotient of num*8192/den
	localparam int LO_W = 21;                 // numerator bits fed into divider steps
	localparam int HOM_W = 32'd32;            // fourth homogeneous term (1.0 in Q.5)

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;

	typedef struct packed {
		logic [15:0] left_x;
		logic [15:0] left_y;
		logic [15:0] right_x;
		logic [15:0] right_y;
	} sdr_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               w_zero;
		logic               saturated;
	} sdr_out_t;

	// sideband carried through the divider with each quotient
	typedef struct packed {
		logic ovf;   // quotient known to exceed range
		logic neg;   // result sign
	} sdr_div_tag_t;

endpackage

`default_nettype wire

### rtl/core/stereo_disparity_reprojection_unit.sv
// ----------------------------------------------------------------------------
// stereo_disparity_reprojection_unit
// Reprojects a matched keypoint pair through a 4x4 Q matrix to X, Y, Z.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | sdr_in_t  (left/right x,y)
// out     | output    | out_valid/ out_stall | sdr_out_t (X, Y, Z, flags)
// cfg     | input     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle unless the output stalls; 4 front stages,
// 35 bit-per-stage divider stages, then the output register.
// Reset clears valid bits and loads the default matrix; no clearing pass.
// A stalled output holds the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_disparity_reprojection_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire sdr_pkg::sdr_in_t                   in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output sdr_pkg::sdr_out_t                       out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [sdr_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire logic [sdr_pkg::REG_W-1:0]          cfg_data
);
	import sdr_pkg::*;

	localparam int DV = QUO_W + 1;   // divider stages

	logic [REG_W-1:0] cfg_q [0:NUM_REGS-1];
	logic             adv;

	// matrix registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= RST_ROW0_C01;
			cfg_q[1] <= RST_ROW0_C23;
			cfg_q[2] <= RST_ROW1_C01;
			cfg_q[3] <= RST_ROW1_C23;
			cfg_q[4] <= RST_ROW2_C01;
			cfg_q[5] <= RST_ROW2_C23;
			cfg_q[6] <= RST_ROW3_C01;
			cfg_q[7] <= RST_ROW3_C23;
		end else if (cfg_valid && cfg_ready && cfg_index < REG_IDX_W'(NUM_REGS)) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// global advance: move when the output register is free or being taken
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	// valid bits
	logic          v_s1, v_s2, v_s3, v_s4;
	logic [DV-1:0] vd_s;
	logic          wz_s5 [0:DV-1];

	// S1: homogeneous vector (x+x', y+y', 2*disparity)
	logic [16:0]          h0_s1, h1_s1;
	logic signed [H_W-1:0] h2_s1;

	// S2: products, S3: dot products
	logic signed [PROD_W-1:0] prod_s2 [0:3][0:3];
	logic signed [DOT_W-1:0]  dot_s3 [0:3];

	// S4: magnitudes and flags
	logic [MAG_W-1:0]  num_s4 [0:2];
	logic [MAG_W-1:0]  den_s4;
	sdr_div_tag_t      tag_s4 [0:2];
	logic              wz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vd_s <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vd_s <= {vd_s[DV-2:0], v_s4};
			out_valid <= vd_s[DV-1];
		end
	end

	// front datapath
	always_ff @(posedge clk) begin
		logic signed [COEF_W-1:0] c;
		logic signed [H_W-1:0]    hv;
		logic signed [DOT_W-1:0]  den_v;
		logic signed [DOT_W-1:0]  neg_v;
		logic [MAG_W-1:0]         dmag;
		logic [MAG_W-1:0]         nmag;
		if (adv) begin
			h0_s1 <= {1'b0, in_data.left_x} + {1'b0, in_data.right_x};
			h1_s1 <= {1'b0, in_data.left_y} + {1'b0, in_data.right_y};
			h2_s1 <= {({1'b0, in_data.left_x} - {1'b0, in_data.right_x}), 1'b0};

			for (int r = 0; r < 4; r++) begin
				for (int k = 0; k < 4; k++) begin
					c = (k % 2 == 0) ? cfg_q[2*r + k/2][63:32] : cfg_q[2*r + k/2][31:0];
					case (k)
						0: hv = $signed({1'b0, h0_s1});
						1: hv = $signed({1'b0, h1_s1});
						2: hv = h2_s1;
						default: hv = H_W'(HOM_W);
					endcase
					prod_s2[r][k] <= c * hv;
				end
			end

			for (int r = 0; r < 4; r++) begin
				dot_s3[r] <= DOT_W'(prod_s2[r][0]) + DOT_W'(prod_s2[r][1])
					+ DOT_W'(prod_s2[r][2]) + DOT_W'(prod_s2[r][3]);
			end

			den_v = dot_s3[3];
			neg_v = -den_v;
			dmag = den_v[DOT_W-1] ? neg_v[MAG_W-1:0] : den_v[MAG_W-1:0];
			den_s4 <= dmag;
			wz_s4 <= (den_v == '0);
			for (int r = 0; r < 3; r++) begin
				neg_v = -dot_s3[r];
				nmag = dot_s3[r][DOT_W-1] ? neg_v[MAG_W-1:0] : dot_s3[r][MAG_W-1:0];
				num_s4[r] <= nmag;
				tag_s4[r].neg <= dot_s3[r][DOT_W-1] ^ den_v[DOT_W-1];
				tag_s4[r].ovf <= {21'b0, nmag} >= {dmag, 21'b0};
			end

			wz_s5[0] <= wz_s4;
			for (int k = 1; k < DV; k++) wz_s5[k] <= wz_s5[k-1];
		end
	end

	// three dividers
	logic [QUO_W-1:0] quo [0:2];
	sdr_div_tag_t     qtag [0:2];

	for (genvar g = 0; g < 3; g++) begin : g_div
		sdr_div u_div (
			.clk     (clk),
			.en      (adv),
			.num     (num_s4[g]),
			.den     (den_s4),
			.tag_in  (tag_s4[g]),
			.quo     (quo[g]),
			.tag_out (qtag[g])
		);
	end

	// round half away from zero, apply sign, saturate
	function automatic logic [32:0] finish(input logic [QUO_W-1:0] q2, input sdr_div_tag_t t);
		logic [QUO_W:0]   qr;
		logic [QUO_W-1:0] q;
		logic [31:0]      v;
		logic             s;
		qr = ({1'b0, q2} + (QUO_W+1)'(1)) >> 1;
		q = qr[QUO_W-1:0];
		s = 1'b0;
		if (t.ovf) begin
			s = 1'b1;
			v = t.neg ? NEG_MAX : POS_MAX;
		end else if (t.neg) begin
			if (q > QUO_W'(NEG_MAX)) begin
				s = 1'b1;
				v = NEG_MAX;
			end else begin
				v = 32'(-q);
			end
		end else if (q > QUO_W'(POS_MAX)) begin
			s = 1'b1;
			v = POS_MAX;
		end else begin
			v = q[31:0];
		end
		return {s, v};
	endfunction

	// output register
	always_ff @(posedge clk) begin
		logic [32:0] fx, fy, fz;
		if (adv) begin
			fx = finish(quo[0], qtag[0]);
			fy = finish(quo[1], qtag[1]);
			fz = finish(quo[2], qtag[2]);
			if (wz_s5[DV-1]) begin
				out_data <= '{out_x: '0, out_y: '0, out_z: '0, w_zero: 1'b1, saturated: 1'b0};
			end else begin
				out_data.out_x <= fx[31:0];
				out_data.out_y <= fy[31:0];
				out_data.out_z <= fz[31:0];
				out_data.w_zero <= 1'b0;
				out_data.saturated <= fx[32] | fy[32] | fz[32];
			end
		end
	end

	// checks
	a_wzero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.w_zero |->
			out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0
			&& !out_data.saturated)
		else $error("w_zero result not cleared");

	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			out_data.out_x == POS_MAX || out_data.out_x == NEG_MAX ||
			out_data.out_y == POS_MAX || out_data.out_y == NEG_MAX ||
			out_data.out_z == POS_MAX || out_data.out_z == NEG_MAX)
		else $error("saturated flag without clipped coordinate");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vd_s) && $stable(v_s4) && out_valid)
		else $error("pipeline moved during stall");

	a_stall_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

endmodule

`default_nettype wire

### rtl/core/sdr_div.sv
// ----------------------------------------------------------------------------
// sdr_div
// Pipelined restoring divider: quo = floor(num * 8192 / den), one quotient
// bit per stage, given num < den * 2^21.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_div (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [sdr_pkg::MAG_W-1:0]  num,
	input  wire logic [sdr_pkg::MAG_W-1:0]  den,
	input  wire sdr_pkg::sdr_div_tag_t      tag_in,
	output logic      [sdr_pkg::QUO_W-1:0]  quo,
	output sdr_pkg::sdr_div_tag_t           tag_out
);
	import sdr_pkg::*;

	logic [MAG_W-1:0]  rem_s [0:QUO_W-1];
	logic [QUO_W-1:0]  lo_s  [0:QUO_W-1];
	logic [QUO_W-1:0]  quo_s [0:QUO_W];
	logic [MAG_W-1:0]  den_s [0:QUO_W-1];
	sdr_div_tag_t      tag_s [0:QUO_W];

	logic [MAG_W-1:0]  nrem_c [0:QUO_W-1];
	logic              ge_c   [0:QUO_W-1];

	// one trial subtract per stage
	always_comb begin
		logic [MAG_W:0]   trial;
		logic [MAG_W+1:0] diff;
		for (int k = 0; k < QUO_W; k++) begin
			trial = {rem_s[k], lo_s[k][QUO_W-1]};
			diff = {1'b0, trial} - {2'b00, den_s[k]};
			ge_c[k] = !diff[MAG_W+1];
			nrem_c[k] = ge_c[k] ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= MAG_W'(num[MAG_W-1:LO_W]);
			lo_s[0]  <= {num[LO_W-1:0], 13'b0};
			quo_s[0] <= '0;
			den_s[0] <= den;
			tag_s[0] <= tag_in;
			for (int k = 0; k < QUO_W - 1; k++) begin
				rem_s[k+1] <= nrem_c[k];
				lo_s[k+1]  <= {lo_s[k][QUO_W-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
			end
			for (int k = 0; k < QUO_W; k++) begin
				quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge_c[k]};
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign quo = quo_s[QUO_W];
	assign tag_out = tag_s[QUO_W];

endmodule

`default_nettype wire
